>>> hw/rtl/tcs_pkg.sv
// Shared types and constants for the trajectory costmap scorer.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
package tcs_pkg;

  // Map and accumulator geometry
  localparam int MAP_SIDE   = 256;
  localparam int SUM_WIDTH  = 48;
  localparam int SIDE_W     = $clog2(MAP_SIDE);
  localparam int ADDR_W     = 2 * SIDE_W;
  localparam int CELL_COUNT = MAP_SIDE * MAP_SIDE;
  localparam int OUT_W      = 48;
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // Special cost bytes
  localparam logic [7:0] COST_UNKNOWN   = 8'd255;
  localparam logic [7:0] COST_LETHAL    = 8'd254;
  localparam logic [7:0] COST_INSCRIBED = 8'd253;

  // Item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_SCORE = 1'b1;

  // Configuration register map
  localparam int CFG_ADDR_W = 5;
  localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [2:0] REG_INV_RES       = 3'd2;
  localparam logic [2:0] REG_MAP_WIDTH     = 3'd3;
  localparam logic [2:0] REG_MAP_HEIGHT    = 3'd4;
  localparam logic [2:0] REG_TRACK_UNKNOWN = 3'd5;
  localparam logic [2:0] REG_CRITICAL_COST = 3'd6;
  localparam logic [2:0] REG_COLLIDE_COST  = 3'd7;

  localparam logic [31:0] INV_RES_RESET = 32'd1310720;
  localparam logic [8:0]  MAP_DIM_RESET = 9'd256;

  typedef struct packed {
    logic signed [31:0] org_x;
    logic signed [31:0] org_y;
    logic [31:0]        inverse_resolution;
    logic [8:0]         map_width;
    logic [8:0]         map_height;
    logic               track_unknown_free;
    logic [31:0]        crit_term;
    logic [31:0]        hit_score;
  } cfg_t;

  // Item fields that ride along the pipeline
  typedef struct packed {
    logic        mode;
    logic [15:0] cell_index;
    logic [7:0]  cell_cost;
    logic        goal_zone;
    logic        last_point;
    logic        last_trajectory;
  } tag_t;

  // Accepted input transaction
  typedef struct packed {
    tag_t               tag;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } item_t;

  // Stage after the scale multiply
  typedef struct packed {
    logic        valid;
    tag_t        tag;
    logic [31:0] cx;
    logic [31:0] cy;
    logic        neg_off_x;
    logic        neg_off_y;
  } xf_t;

  // Stage holding the memory read
  typedef struct packed {
    logic valid;
    tag_t tag;
    logic off_map;
  } cell_t;

  typedef struct packed {
    logic [OUT_W-1:0] repulsive_cost;
    logic             trajectory_collides;
    logic             all_collide;
    logic             batch_done;
  } result_t;

endpackage

>>> hw/rtl/tcs_item_if.sv
// Input channel: valid/ready handshake with one load or score item.
// Depends on nothing.
`timescale 1ns / 1ps
interface tcs_item_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [15:0]        cell_index;
  logic [7:0]         cell_cost;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               goal_zone;
  logic               last_point;
  logic               last_trajectory;

  modport source (
    output valid, mode, cell_index, cell_cost, point_x, point_y,
           goal_zone, last_point, last_trajectory,
    input  ready
  );
  modport sink (
    input  valid, mode, cell_index, cell_cost, point_x, point_y,
           goal_zone, last_point, last_trajectory,
    output ready
  );
endinterface

>>> hw/rtl/tcs_score_if.sv
// Output channel: valid/ready handshake with one trajectory score.
// Depends on nothing.
`timescale 1ns / 1ps
interface tcs_score_if;
  logic        valid;
  logic        ready;
  logic [47:0] repulsive_cost;
  logic        trajectory_collides;
  logic        all_collide;
  logic        batch_done;

  modport source (
    output valid, repulsive_cost, trajectory_collides, all_collide, batch_done,
    input  ready
  );
  modport sink (
    input  valid, repulsive_cost, trajectory_collides, all_collide, batch_done,
    output ready
  );
endinterface

>>> hw/rtl/trajectory_costmap_scorer_unit.sv
// Top level of the trajectory costmap scorer: configuration registers and pipeline.
// Depends on tcs_pkg, tcs_item_if, tcs_score_if and the tcs_* modules.
//
//   channel  | kind            | carries
//   ---------+-----------------+---------------------------------------------
//   item     | valid/ready in  | cell load or trajectory point
//   score    | valid/ready out | score, collision, batch flags on last point
//   APB      | register port   | eight configuration registers, 4-byte stride
//
// One item per cycle sustained while the result buffer has a free slot. The stages are subtract,
// scale multiply, costmap memory access, and accumulate into the result buffer.
// Reset clears control state only; the costmap has no clearing pass and holds
// whatever was loaded. The pipeline halts as a whole while the two-entry
// result buffer is full, and item.ready drops then.
`timescale 1ns / 1ps
module trajectory_costmap_scorer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tcs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  tcs_item_if.sink                       item,
  tcs_score_if.source                    score
);
  import tcs_pkg::*;

  cfg_t       cfg;
  item_t      in_item;
  xf_t        xf;
  cell_t      rd_stage;
  result_t    res;
  logic [7:0] rd_cost;
  logic       adv;
  logic       push;
  logic       cfg_wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.org_x              <= '0;
      cfg.org_y              <= '0;
      cfg.inverse_resolution <= INV_RES_RESET;
      cfg.map_width          <= MAP_DIM_RESET;
      cfg.map_height         <= MAP_DIM_RESET;
      cfg.track_unknown_free <= 1'b0;
      cfg.crit_term          <= '0;
      cfg.hit_score          <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ORIGIN_X:      cfg.org_x              <= pwdata;
        REG_ORIGIN_Y:      cfg.org_y              <= pwdata;
        REG_INV_RES:       cfg.inverse_resolution <= pwdata;
        REG_MAP_WIDTH:     cfg.map_width          <= pwdata[8:0];
        REG_MAP_HEIGHT:    cfg.map_height         <= pwdata[8:0];
        REG_TRACK_UNKNOWN: cfg.track_unknown_free <= pwdata[0];
        REG_CRITICAL_COST: cfg.crit_term          <= pwdata;
        REG_COLLIDE_COST:  cfg.hit_score          <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (reg_idx)
      REG_ORIGIN_X:      prdata = cfg.org_x;
      REG_ORIGIN_Y:      prdata = cfg.org_y;
      REG_INV_RES:       prdata = cfg.inverse_resolution;
      REG_MAP_WIDTH:     prdata = 32'(cfg.map_width);
      REG_MAP_HEIGHT:    prdata = 32'(cfg.map_height);
      REG_TRACK_UNKNOWN: prdata = 32'(cfg.track_unknown_free);
      REG_CRITICAL_COST: prdata = cfg.crit_term;
      REG_COLLIDE_COST:  prdata = cfg.hit_score;
      default:           prdata = '0;
    endcase
  end

  // Gather the input transaction
  assign item.ready                  = adv;
  assign in_item.tag.mode            = item.mode;
  assign in_item.tag.cell_index      = item.cell_index;
  assign in_item.tag.cell_cost       = item.cell_cost;
  assign in_item.tag.goal_zone       = item.goal_zone;
  assign in_item.tag.last_point      = item.last_point;
  assign in_item.tag.last_trajectory = item.last_trajectory;
  assign in_item.point_x             = item.point_x;
  assign in_item.point_y             = item.point_y;

  tcs_map_xform u_xform (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (item.valid),
    .in_item  (in_item),
    .cfg      (cfg),
    .xf       (xf)
  );

  tcs_cell_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .xf       (xf),
    .cfg      (cfg),
    .rd_stage (rd_stage),
    .rd_cost  (rd_cost)
  );

  tcs_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .rd_stage (rd_stage),
    .rd_cost  (rd_cost),
    .cfg      (cfg),
    .push     (push),
    .res      (res)
  );

  tcs_out_buf u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .res   (res),
    .adv   (adv),
    .score (score)
  );

endmodule

>>> hw/rtl/tcs_map_xform.sv
// Point-to-cell transform: origin subtract, then scale multiply per axis.
// Depends on tcs_pkg.
`timescale 1ns / 1ps
module tcs_map_xform (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  tcs_pkg::item_t in_item,
  input  tcs_pkg::cfg_t  cfg,
  output tcs_pkg::xf_t   xf
);
  import tcs_pkg::*;

  logic               s1_valid;
  tag_t               s1_tag;
  logic signed [32:0] s1_dx;
  logic signed [32:0] s1_dy;
  logic [63:0]        prod_x;
  logic [63:0]        prod_y;
  logic               inv_nonzero;

  // Stage 1: offset from the map origin
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
    if (adv) begin
      s1_tag <= in_item.tag;
      s1_dx  <= 33'(in_item.point_x) - 33'(cfg.org_x);
      s1_dy  <= 33'(in_item.point_y) - 33'(cfg.org_y);
    end
  end

  // Scale by cells per meter; a non-negative offset fits in 32 bits
  assign prod_x      = 64'(s1_dx[31:0]) * 64'(cfg.inverse_resolution);
  assign prod_y      = 64'(s1_dy[31:0]) * 64'(cfg.inverse_resolution);
  assign inv_nonzero = (cfg.inverse_resolution != 32'd0);

  // Stage 2: floored cell coordinate, negative offsets flagged when the scale is nonzero
  always_ff @(posedge clk) begin
    if (rst) begin
      xf.valid <= 1'b0;
    end else if (adv) begin
      xf.valid <= s1_valid;
    end
    if (adv) begin
      xf.tag       <= s1_tag;
      xf.cx        <= s1_dx[32] ? 32'd0 : prod_x[63:32];
      xf.cy        <= s1_dy[32] ? 32'd0 : prod_y[63:32];
      xf.neg_off_x <= s1_dx[32] && inv_nonzero;
      xf.neg_off_y <= s1_dy[32] && inv_nonzero;
    end
  end

endmodule

>>> hw/rtl/tcs_cell_mem.sv
// Costmap store: bounds check, then a synchronous read, plus a write for loads, per transaction.
// Depends on tcs_pkg.
`timescale 1ns / 1ps
module tcs_cell_mem (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  tcs_pkg::xf_t  xf,
  input  tcs_pkg::cfg_t cfg,
  output tcs_pkg::cell_t rd_stage,
  output logic [7:0]    rd_cost
);
  import tcs_pkg::*;

  logic [7:0]        cells [CELL_COUNT];
  logic [31:0]       lim_x;
  logic [31:0]       lim_y;
  logic              on_map;
  logic              load_ok;
  logic [ADDR_W-1:0] mem_addr;

  // Clip the map size to the store and check the cell against it
  always_comb begin
    lim_x  = (32'(cfg.map_width) > 32'(MAP_SIDE)) ? 32'(MAP_SIDE) : 32'(cfg.map_width);
    lim_y  = (32'(cfg.map_height) > 32'(MAP_SIDE)) ? 32'(MAP_SIDE) : 32'(cfg.map_height);
    on_map = !xf.neg_off_x && !xf.neg_off_y && (xf.cx < lim_x) && (xf.cy < lim_y);
  end

  // Loads use the item address, points the row/column address
  assign load_ok  = (32'(xf.tag.cell_index) < 32'(CELL_COUNT));
  assign mem_addr = (xf.tag.mode == MODE_SCORE) ? {xf.cy[SIDE_W-1:0], xf.cx[SIDE_W-1:0]}
                                                : ADDR_W'(xf.tag.cell_index);

  // Single port: write for loads, registered read for points
  always_ff @(posedge clk) begin
    if (adv && xf.valid) begin
      if (xf.tag.mode == MODE_LOAD && load_ok) begin
        cells[mem_addr] <= xf.tag.cell_cost;
      end
      rd_cost <= cells[mem_addr];
    end
  end

  // Stage 3: carry the tag beside the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_stage.valid <= 1'b0;
    end else if (adv) begin
      rd_stage.valid <= xf.valid;
    end
    if (adv) begin
      rd_stage.tag     <= xf.tag;
      rd_stage.off_map <= !on_map;
    end
  end

endmodule

>>> hw/rtl/tcs_accum.sv
// Per-point term, saturating trajectory sum and collision flags.
// Depends on tcs_pkg.
`timescale 1ns / 1ps
module tcs_accum (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  tcs_pkg::cell_t  rd_stage,
  input  logic [7:0]      rd_cost,
  input  tcs_pkg::cfg_t   cfg,
  output logic            push,
  output tcs_pkg::result_t res
);
  import tcs_pkg::*;

  logic [SUM_WIDTH-1:0] cost_sum;
  logic [SUM_WIDTH-1:0] cost_sum_next;
  logic                 hit_flag;
  logic                 all_hit_flag;
  logic                 fire;
  logic [7:0]           cost;
  logic                 collide;
  logic                 hit_now;
  logic                 all_now;
  logic [SUM_WIDTH-1:0] term;
  logic [SUM_WIDTH:0]   sum_add;
  logic [63:0]          score;

  assign fire = adv && rd_stage.valid && (rd_stage.tag.mode == MODE_SCORE);
  assign push = fire && rd_stage.tag.last_point;

  // Classify the cell and form its term
  always_comb begin
    cost    = rd_stage.off_map ? COST_UNKNOWN : rd_cost;
    collide = (cost == COST_LETHAL) || (cost == COST_INSCRIBED) ||
              ((cost == COST_UNKNOWN) && !cfg.track_unknown_free);
    if (cost == 8'd0) begin
      term = '0;
    end else if (cost >= COST_INSCRIBED) begin
      term = SUM_WIDTH'(cfg.crit_term);
    end else if (rd_stage.tag.goal_zone) begin
      term = '0;
    end else begin
      term = SUM_WIDTH'({cost, 16'd0});
    end
    sum_add       = {1'b0, cost_sum} + {1'b0, term};
    cost_sum_next = sum_add[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : sum_add[SUM_WIDTH-1:0];
    hit_now       = hit_flag || collide;
    all_now       = all_hit_flag && hit_now;
  end

  // Score of the finished trajectory, clipped to the output width
  always_comb begin
    score                   = hit_now ? 64'(cfg.hit_score) : 64'(cost_sum_next);
    res.repulsive_cost      = (score > 64'(OUT_MAX)) ? OUT_MAX : score[OUT_W-1:0];
    res.trajectory_collides = hit_now;
    res.all_collide         = rd_stage.tag.last_trajectory && all_now;
    res.batch_done          = rd_stage.tag.last_trajectory;
  end

  // Advance the running state; clear the sum and hit flag at the end of each trajectory
  always_ff @(posedge clk) begin
    if (rst) begin
      cost_sum     <= '0;
      hit_flag     <= 1'b0;
      all_hit_flag <= 1'b1;
    end else if (fire) begin
      if (rd_stage.tag.last_point) begin
        cost_sum     <= '0;
        hit_flag     <= 1'b0;
        all_hit_flag <= rd_stage.tag.last_trajectory ? 1'b1 : all_now;
      end else begin
        cost_sum <= cost_sum_next;
        hit_flag <= hit_now;
      end
    end
  end

  // A trajectory end leaves a clean sum and collision flag
  a_traj_clear: assert property (@(posedge clk) disable iff (rst)
    push |=> (cost_sum == '0) && !hit_flag)
    else $error("trajectory state not cleared after last point");

  // A batch end restores the all-collide flag
  a_batch_clear: assert property (@(posedge clk) disable iff (rst)
    (push && rd_stage.tag.last_trajectory) |=> all_hit_flag)
    else $error("batch flag not restored after last trajectory");

endmodule

>>> hw/rtl/tcs_out_buf.sv
// Two-entry result buffer that decouples the pipeline from the output channel.
// Depends on tcs_pkg and tcs_score_if.
`timescale 1ns / 1ps
module tcs_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tcs_pkg::result_t res,
  output logic             adv,
  tcs_score_if.source      score
);
  import tcs_pkg::*;

  result_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  // Pipeline moves only while a slot is free
  assign adv = (count != 2'd2);
  assign pop = score.valid && score.ready;

  assign score.valid               = (count != 2'd0);
  assign score.repulsive_cost      = entries[rd_ptr].repulsive_cost;
  assign score.trajectory_collides = entries[rd_ptr].trajectory_collides;
  assign score.all_collide         = entries[rd_ptr].all_collide;
  assign score.batch_done          = entries[rd_ptr].batch_done;

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= res;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    !(count == 2'd2 && push))
    else $error("result pushed into a full buffer");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("buffer count out of range");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 2'd1))
    else $error("buffer count did not drop on pop");

endmodule
